>>> design/particle_truncation_resampler_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the truncation resampler.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_TRUNCATION_RESAMPLER_MACROS_SVH
`define PARTICLE_TRUNCATION_RESAMPLER_MACROS_SVH

// same-cycle implication
`define PTR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// stalled item stays valid and unchanged
`define PTR_ASSERT_HOLD(lbl, vld, stl, dat, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && (stl)) |=> ((vld) && $stable(dat))) \
    else $error(msg);

`endif

>>> design/ptr_pkg.sv
// ---------------------------------------------------------------------------
// ptr_pkg
// Types and constants shared by the truncation resampler modules.
// ---------------------------------------------------------------------------
package ptr_pkg;

  localparam int PTR_MAX_PARTICLES = 32;
  localparam int PTR_CNT_W         = 6;
  localparam int PTR_QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [15:0] scale_q;
    logic [11:0] box_width;
    logic [11:0] box_height;
    logic [31:0] weight;
    logic [31:0] color_score;
    logic        set_end;
  } ptr_in_t;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [15:0] out_scale;
    logic [11:0] out_box_width;
    logic [11:0] out_box_height;
    logic [31:0] out_weight;
    logic [31:0] out_color;
    logic        run_end;
  } ptr_out_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] scale;
    logic [11:0] bw;
    logic [11:0] bh;
    logic [31:0] wt;
    logic [31:0] col;
  } ptr_cell_t;

  typedef struct packed {
    ptr_cell_t particle;
    logic      keep;
    logic      last;
  } ptr_qitem_t;

  typedef struct packed {
    logic                 emitting;
    logic [PTR_CNT_W-1:0] count;
  } ptr_back_stat_t;

  typedef enum logic {
    PTR_LOAD,
    PTR_EMIT
  } ptr_back_state_e;

endpackage

>>> design/particle_truncation_resampler.sv
// ---------------------------------------------------------------------------
// particle_truncation_resampler: one particle per cycle, unless stalled,
// into a sort chain. After the set_end item, 2*floor(N/2) results go out
// at one per cycle while out_stall_i is low, loading held while they
// drain. Reset clears all control state at once; no clearing pass.
// ---------------------------------------------------------------------------
`include "particle_truncation_resampler_macros.svh"

module particle_truncation_resampler import ptr_pkg::*; #(
  parameter int MAX_PARTICLES = PTR_MAX_PARTICLES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ptr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ptr_out_t out_data_o
);

  logic           q_push, q_full, q_pop, q_valid;
  ptr_qitem_t     q_in, q_out;
  ptr_back_stat_t stat;

  ptr_front #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (q_in)
  );

  ptr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_out)
  );

  ptr_back #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .stat_o     (stat)
  );

  `PTR_ASSERT_IMP(a_no_pop_emit, stat.emitting, !q_pop, "queue popped while emitting")
  `PTR_ASSERT_HOLD(a_out_hold, out_valid_o, out_stall_i, out_data_o, "stalled item changed")
  `PTR_ASSERT_IMP(a_cnt_range, 1'b1, stat.count <= PTR_CNT_W'(MAX_PARTICLES), "count overflow")
  `PTR_ASSERT_NXT(a_clr, q_pop && q_out.last && (stat.count == '0), stat.count == '0, "count kept")

endmodule

>>> design/ptr_front.sv
// ---------------------------------------------------------------------------
// ptr_front
// Accepts particles, tags each as stored or dropped, and pushes it to the queue.
// ---------------------------------------------------------------------------
module ptr_front import ptr_pkg::*; #(
  parameter int MAX_PARTICLES = PTR_MAX_PARTICLES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ptr_in_t    in_data_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output ptr_qitem_t q_item_o
);

  localparam int CntW = $clog2(MAX_PARTICLES + 1);

  logic [CntW-1:0] fcnt_q, fcnt_d;
  logic            keep;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign keep       = fcnt_q < CntW'(MAX_PARTICLES);

  always_comb begin
    q_item_o.particle.x     = in_data_i.pos_x;
    q_item_o.particle.y     = in_data_i.pos_y;
    q_item_o.particle.scale = in_data_i.scale_q;
    q_item_o.particle.bw    = in_data_i.box_width;
    q_item_o.particle.bh    = in_data_i.box_height;
    q_item_o.particle.wt    = in_data_i.weight;
    q_item_o.particle.col   = in_data_i.color_score;
    q_item_o.keep           = keep;
    q_item_o.last           = in_data_i.set_end;
  end

  always_comb begin
    fcnt_d = fcnt_q;
    if (q_push_o) begin
      if (in_data_i.set_end) begin
        fcnt_d = '0;
      end else if (keep) begin
        fcnt_d = fcnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_d;
    end
  end

endmodule

>>> design/ptr_queue.sv
// ---------------------------------------------------------------------------
// ptr_queue
// Short FIFO that decouples the front from the sort and emit back end.
// ---------------------------------------------------------------------------
module ptr_queue import ptr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ptr_qitem_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output ptr_qitem_t item_o
);

  localparam int AddrW = $clog2(PTR_QUEUE_DEPTH);
  localparam int CntW  = $clog2(PTR_QUEUE_DEPTH + 1);

  ptr_qitem_t       mem_q [PTR_QUEUE_DEPTH];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(PTR_QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> design/ptr_back.sv
// ---------------------------------------------------------------------------
// ptr_back
// Insertion-sort cell chain, heaviest first, then duplicated top-half emission.
// ---------------------------------------------------------------------------
module ptr_back import ptr_pkg::*; #(
  parameter int MAX_PARTICLES = PTR_MAX_PARTICLES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ptr_qitem_t     q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ptr_out_t       out_data_o,
  output ptr_back_stat_t stat_o
);

  localparam int CntW = $clog2(MAX_PARTICLES + 1);

  ptr_back_state_e          state_q, state_d;
  ptr_cell_t                cell_q [MAX_PARTICLES];
  logic [MAX_PARTICLES-1:0] vld_q, vld_d, ge;
  logic [CntW-1:0]          cnt_q, cnt_d, rem_q, rem_d, sum, half;
  logic                     copy_q, copy_d;
  logic                     out_vld_q;
  ptr_out_t                 out_q;
  logic                     ins, shift, clr, out_load;

  assign out_valid_o     = out_vld_q;
  assign out_data_o      = out_q;
  assign stat_o.emitting = state_q == PTR_EMIT;
  assign stat_o.count    = PTR_CNT_W'(cnt_q);

  assign ins  = (state_q == PTR_LOAD) && q_valid_i && q_item_i.keep;
  assign sum  = cnt_q + CntW'(ins);
  assign half = sum >> 1;

  always_comb begin
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      ge[i] = vld_q[i] && (cell_q[i].wt >= q_item_i.particle.wt);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    copy_d   = copy_q;
    shift    = 1'b0;
    clr      = 1'b0;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      PTR_LOAD: begin
        q_pop_o = q_valid_i;
        if (q_pop_o) begin
          cnt_d = sum;
          if (q_item_i.last) begin
            if (half == '0) begin
              clr   = 1'b1;
              cnt_d = '0;
            end else begin
              state_d = PTR_EMIT;
              rem_d   = half;
              copy_d  = 1'b0;
            end
          end
        end
      end
      PTR_EMIT: begin
        out_load = !out_vld_q || !out_stall_i;
        if (out_load) begin
          if (copy_q) begin
            shift  = 1'b1;
            copy_d = 1'b0;
            rem_d  = rem_q - CntW'(1);
            if (rem_q == CntW'(1)) begin
              clr     = 1'b1;
              cnt_d   = '0;
              state_d = PTR_LOAD;
            end
          end else begin
            copy_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = PTR_LOAD;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      vld_d[i] = clr ? 1'b0 : (vld_q[i] || (ins && (cnt_q == CntW'(i))));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PARTICLES; i++) begin
      if (ins) begin
        if (!ge[i]) begin
          if (i == 0) begin
            cell_q[i] <= q_item_i.particle;
          end else if (ge[i-1]) begin
            cell_q[i] <= q_item_i.particle;
          end else begin
            cell_q[i] <= cell_q[i-1];
          end
        end
      end else if (shift && (i < MAX_PARTICLES - 1)) begin
        cell_q[i] <= cell_q[i+1];
      end
    end
    if (out_load) begin
      out_q.out_x          <= cell_q[0].x;
      out_q.out_y          <= cell_q[0].y;
      out_q.out_scale      <= cell_q[0].scale;
      out_q.out_box_width  <= cell_q[0].bw;
      out_q.out_box_height <= cell_q[0].bh;
      out_q.out_weight     <= cell_q[0].wt;
      out_q.out_color      <= cell_q[0].col;
      out_q.run_end        <= copy_q && (rem_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= PTR_LOAD;
      vld_q     <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      copy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      copy_q  <= copy_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule
